@@ sv/wfa_pkg.sv @@
// shared types and constants for the wfa pixel decoder
// no dependencies; imported by wfa_mac and wfa_pixel_decoder_unit
package wfa_pkg;

    localparam int DEF_MAX_STATES  = 8;
    localparam int DEF_MAX_LEVELS  = 10;
    localparam int DEF_WEIGHT_W    = 24;

    // running vector format: signed, 16 fraction bits
    localparam int VEC_W    = 40;
    localparam int FRAC_W   = 16;
    // vector element is split into a signed high part and an unsigned low part
    localparam int SPLIT_W  = 20;
    localparam int OPND_W   = VEC_W - SPLIT_W + 1;

    localparam int FIELD_IDX_W = 3;
    localparam int WEIGHT_IN_W = 24;
    localparam int COORD_W     = 10;
    localparam int GRAY_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATES = 2'd1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [FIELD_IDX_W-1:0] SEL_FINAL = 3'd4;

    localparam logic [CFG_DATA_W-1:0] LEVELS_RESET = 4'd9;
    localparam logic [CFG_DATA_W-1:0] STATES_RESET = 4'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } seq_state_t;

    // control that travels with one operand pair into the multiply-accumulate
    typedef struct packed {
        logic valid;
        logic half;   // 1: low part of the vector element, 0: high part
        logic last;   // last product of this dot product
    } mac_ctrl_t;

endpackage

@@ sv/wfa_mac.sv @@
// shared multiply-accumulate for the wfa pixel decoder dot products
// depends on wfa_pkg; exact split product sums, floor shift, saturation, gray clamp
module wfa_mac #(
    parameter int MAX_STATES   = wfa_pkg::DEF_MAX_STATES,
    parameter int WEIGHT_WIDTH = wfa_pkg::DEF_WEIGHT_W
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wfa_pkg::mac_ctrl_t                    ctrl,
    input  logic                                  clear,
    input  logic signed [wfa_pkg::VEC_W-1:0]      vec_el,
    input  logic signed [WEIGHT_WIDTH-1:0]        weight,
    output logic                                  done,
    output logic signed [wfa_pkg::VEC_W-1:0]      vec_sat,
    output logic                                  vec_ovf,
    output logic [wfa_pkg::GRAY_W-1:0]            gray,
    output logic                                  gray_ovf
);
    import wfa_pkg::*;

    localparam int SW     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int PROD_W = OPND_W + WEIGHT_WIDTH;
    localparam int ACC_W  = PROD_W + SW + 1;
    localparam int SUM_A  = ACC_W + (SPLIT_W - FRAC_W);
    localparam int SUM_W  = (SUM_A > VEC_W + 1) ? SUM_A : VEC_W + 1;

    logic signed [OPND_W-1:0] opnd;
    logic signed [PROD_W-1:0] prod_reg;
    mac_ctrl_t                ctrl2_reg;
    logic signed [ACC_W-1:0]  hi_reg;
    logic signed [ACC_W-1:0]  lo_reg;
    logic                     done_reg;
    logic signed [SUM_W-1:0]  sum;
    logic                     upper_zero;
    logic                     upper_ones;

    assign opnd = ctrl.half ? $signed({1'b0, vec_el[SPLIT_W-1:0]})
                            : $signed({vec_el[VEC_W-1], vec_el[VEC_W-1:SPLIT_W]});

    always_ff @(posedge clk)
    begin
        prod_reg <= opnd * weight;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl2_reg <= '0;
            done_reg  <= 1'b0;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end
        else
        begin
            ctrl2_reg <= ctrl;
            done_reg  <= ctrl2_reg.valid && ctrl2_reg.last;
            if (clear)
            begin
                hi_reg <= '0;
                lo_reg <= '0;
            end
            else if (ctrl2_reg.valid)
            begin
                if (ctrl2_reg.half)
                    lo_reg <= lo_reg + ACC_W'(prod_reg);
                else
                    hi_reg <= hi_reg + ACC_W'(prod_reg);
            end
        end
    end

    // floor(sum / 2^16) = hi * 16 + floor(lo / 2^16)
    assign sum = (SUM_W'(hi_reg) <<< (SPLIT_W - FRAC_W)) + SUM_W'(lo_reg >>> FRAC_W);

    assign upper_zero = (sum[SUM_W-1:VEC_W-1] == '0);
    assign upper_ones = (sum[SUM_W-1:VEC_W-1] == '1);

    always_comb
    begin
        vec_ovf = !(upper_zero || upper_ones);
        if (!vec_ovf)
            vec_sat = sum[VEC_W-1:0];
        else if (sum[SUM_W-1])
            vec_sat = {1'b1, {(VEC_W-1){1'b0}}};
        else
            vec_sat = {1'b0, {(VEC_W-1){1'b1}}};
    end

    always_comb
    begin
        gray_ovf = 1'b1;
        if (sum[SUM_W-1])
            gray = '0;
        else if (sum[SUM_W-1:GRAY_W] != '0)
            gray = '1;
        else
        begin
            gray     = sum[GRAY_W-1:0];
            gray_ovf = 1'b0;
        end
    end

    assign done = done_reg;

endmodule

@@ sv/wfa_pixel_decoder_unit.sv @@
// top level of the wfa pixel decoder: weight store, running vector, sequencer
// depends on wfa_pkg and wfa_mac
//
// Decodes one gray pixel of an image held as a weighted finite automaton. A
// request with op = write stores one weight (matrix A..D or the final vector)
// in the same cycle it is taken and gives no result. A request with op = decode
// starts from e0, multiplies the row vector by the quadrant matrix of each
// address bit from the top bit down, then takes the dot product with the final
// weights. One shared 21 x WEIGHT_WIDTH multiplier does every product, each
// vector element in two halves. busy stays high for the whole decode and start
// is ignored meanwhile. The result is held on gray_level and clamped until the
// next result and is marked by done for exactly one cycle; there is no way to
// stall it, so the receiver must take it in that cycle. Configuration writes
// are always taken (cfg_ready is tied high) and must only be issued while idle.
module wfa_pixel_decoder_unit #(
    parameter int MAX_STATES   = wfa_pkg::DEF_MAX_STATES,
    parameter int MAX_LEVELS   = wfa_pkg::DEF_MAX_LEVELS,
    parameter int WEIGHT_WIDTH = wfa_pkg::DEF_WEIGHT_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic [wfa_pkg::FIELD_IDX_W-1:0]     matrix_sel,
    input  logic [wfa_pkg::FIELD_IDX_W-1:0]     row_index,
    input  logic [wfa_pkg::FIELD_IDX_W-1:0]     col_index,
    input  logic signed [wfa_pkg::WEIGHT_IN_W-1:0] weight_value,
    input  logic [wfa_pkg::COORD_W-1:0]         pixel_x,
    input  logic [wfa_pkg::COORD_W-1:0]         pixel_y,
    // result strobe
    output logic                                done,
    output logic [wfa_pkg::GRAY_W-1:0]          gray_level,
    output logic                                clamped,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [wfa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wfa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import wfa_pkg::*;

    localparam int SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int LW  = $clog2(MAX_LEVELS + 1);
    localparam int LXW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic signed [VEC_W-1:0] VEC_ONE = VEC_W'(1) << FRAC_W;

    // configuration registers
    logic [CFG_DATA_W-1:0] levels_reg;
    logic [CFG_DATA_W-1:0] states_reg;

    // sequencer state
    seq_state_t      state_reg, state_next;
    logic [SW:0]     k_reg, k_next;        // {element index, half}
    logic [SW-1:0]   j_reg, j_next;        // output column
    logic [SW-1:0]   nm1_reg, nm1_next;    // states in use minus one
    logic [LW-1:0]   lvl_reg, lvl_next;    // address bits still to go
    logic            bank_reg, bank_next;  // bank holding the current vector
    logic            e0_reg, e0_next;      // current vector is still e0
    logic            flag_reg, flag_next;  // sticky saturation flag
    logic [MAX_LEVELS-1:0] x_reg, x_next;
    logic [MAX_LEVELS-1:0] y_reg, y_next;

    // result registers
    logic               done_reg, done_next;
    logic [GRAY_W-1:0]  gray_reg, gray_next;
    logic               clamped_reg, clamped_next;

    // weight store and running vector
    logic signed [WEIGHT_WIDTH-1:0] tw_mem [4][MAX_STATES][MAX_STATES];
    logic signed [WEIGHT_WIDTH-1:0] fw_mem [MAX_STATES];
    logic signed [VEC_W-1:0]        vec_mem [2][MAX_STATES];
    logic signed [WEIGHT_WIDTH-1:0] tw_rd_reg;
    logic signed [WEIGHT_WIDTH-1:0] fw_rd_reg;
    logic signed [VEC_W-1:0]        v_rd_reg;
    logic                           final_rd_reg;

    mac_ctrl_t ctrl_reg, ctrl_next;
    logic      mac_clear;
    logic      vec_we;

    // mac outputs
    logic                    mac_done;
    logic signed [VEC_W-1:0] mac_vec;
    logic                    mac_vec_ovf;
    logic [GRAY_W-1:0]       mac_gray;
    logic                    mac_gray_ovf;

    logic                    accept;
    logic                    wr_en;
    logic                    wr_row_ok;
    logic                    wr_col_ok;
    logic [SW-1:0]           wr_row;
    logic [SW-1:0]           wr_col;
    logic signed [WEIGHT_WIDTH-1:0] wr_weight;
    logic [SW-1:0]           i_cur;
    logic [LXW-1:0]          bit_idx;
    logic [1:0]              q_cur;
    logic                    issue_last;
    logic [SW-1:0]           nm1_eff;
    logic [LW-1:0]           lv_eff;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= LEVELS_RESET;
            states_reg <= STATES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_LEVELS)
                levels_reg <= cfg_data;
            else if (cfg_index == CFG_STATES)
                states_reg <= cfg_data;
        end
    end

    // out-of-range register values are pulled into range at decode start
    always_comb
    begin
        if (states_reg == '0)
            nm1_eff = '0;
        else if (32'(states_reg) > MAX_STATES)
            nm1_eff = SW'(MAX_STATES - 1);
        else
            nm1_eff = SW'(states_reg - 1'b1);

        if (32'(levels_reg) > MAX_LEVELS)
            lv_eff = LW'(MAX_LEVELS);
        else
            lv_eff = LW'(levels_reg);
    end

    // weight write decode; bad selector or index is dropped
    assign wr_row_ok = (32'(row_index) < MAX_STATES);
    assign wr_col_ok = (32'(col_index) < MAX_STATES);
    assign wr_row    = SW'(row_index);
    assign wr_col    = SW'(col_index);
    assign wr_weight = WEIGHT_WIDTH'(weight_value);
    assign wr_en     = accept && (op == OP_WRITE) && wr_row_ok
                       && ((matrix_sel < SEL_FINAL && wr_col_ok) || matrix_sel == SEL_FINAL);

    // operand addressing
    assign i_cur      = k_reg[SW:1];
    assign issue_last = (i_cur == nm1_reg) && k_reg[0];
    assign bit_idx    = LXW'(lvl_reg - 1'b1);
    assign q_cur      = {y_reg[bit_idx], x_reg[bit_idx]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (matrix_sel == SEL_FINAL)
                fw_mem[wr_row] <= wr_weight;
            else
                tw_mem[matrix_sel[1:0]][wr_row][wr_col] <= wr_weight;
        end
    end

    // registered reads, one address each
    always_ff @(posedge clk)
    begin
        tw_rd_reg    <= tw_mem[q_cur][i_cur][j_reg];
        fw_rd_reg    <= fw_mem[i_cur];
        final_rd_reg <= (lvl_reg == '0);
        if (e0_reg)
            v_rd_reg <= (i_cur == '0) ? VEC_ONE : '0;
        else
            v_rd_reg <= vec_mem[bank_reg][i_cur];
    end

    // next vector goes to the other bank
    always_ff @(posedge clk)
    begin
        if (vec_we)
            vec_mem[!bank_reg][j_reg] <= mac_vec;
    end

    wfa_mac #(
        .MAX_STATES   (MAX_STATES),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl_reg),
        .clear    (mac_clear),
        .vec_el   (v_rd_reg),
        .weight   (final_rd_reg ? fw_rd_reg : tw_rd_reg),
        .done     (mac_done),
        .vec_sat  (mac_vec),
        .vec_ovf  (mac_vec_ovf),
        .gray     (mac_gray),
        .gray_ovf (mac_gray_ovf)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        nm1_next     = nm1_reg;
        lvl_next     = lvl_reg;
        bank_next    = bank_reg;
        e0_next      = e0_reg;
        flag_next    = flag_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        done_next    = 1'b0;
        gray_next    = gray_reg;
        clamped_next = clamped_reg;
        ctrl_next    = '0;
        mac_clear    = 1'b0;
        vec_we       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_DECODE)
                begin
                    x_next     = MAX_LEVELS'(pixel_x);
                    y_next     = MAX_LEVELS'(pixel_y);
                    nm1_next   = nm1_eff;
                    lvl_next   = lv_eff;
                    bank_next  = 1'b0;
                    e0_next    = 1'b1;
                    flag_next  = 1'b0;
                    j_next     = '0;
                    k_next     = '0;
                    mac_clear  = 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                ctrl_next.valid = 1'b1;
                ctrl_next.half  = k_reg[0];
                ctrl_next.last  = issue_last;
                if (issue_last)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_DRAIN:
            begin
                if (mac_done)
                begin
                    mac_clear = 1'b1;
                    if (lvl_reg == '0)
                    begin
                        // final dot product done: present the pixel
                        done_next    = 1'b1;
                        gray_next    = mac_gray;
                        clamped_next = flag_reg || mac_gray_ovf;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        vec_we    = 1'b1;
                        flag_next = flag_reg || mac_vec_ovf;
                        if (j_reg == nm1_reg)
                        begin
                            j_next    = '0;
                            lvl_next  = lvl_reg - 1'b1;
                            bank_next = !bank_reg;
                            e0_next   = 1'b0;
                        end
                        else
                            j_next = j_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctrl_reg  <= '0;
            done_reg  <= 1'b0;
            k_reg     <= '0;
            j_reg     <= '0;
            nm1_reg   <= '0;
            lvl_reg   <= '0;
            bank_reg  <= 1'b0;
            e0_reg    <= 1'b1;
            flag_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctrl_reg  <= ctrl_next;
            done_reg  <= done_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            nm1_reg   <= nm1_next;
            lvl_reg   <= lvl_next;
            bank_reg  <= bank_next;
            e0_reg    <= e0_next;
            flag_reg  <= flag_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        gray_reg    <= gray_next;
        clamped_reg <= clamped_next;
    end

    assign done       = done_reg;
    assign gray_level = gray_reg;
    assign clamped    = clamped_reg;

    // the multiply pipeline is empty whenever the sequencer is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ctrl_reg.valid)
        else $error("mac pipeline busy while sequencer idle");

    // a result only follows the end of a dot product
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg == S_DRAIN) && $past(mac_done) && !busy))
        else $error("result strobe without finished dot product");

    // dot product completion is only seen while waiting for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_DRAIN))
        else $error("mac completion outside drain");

    // element index never passes the states in use
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ISSUE) |-> (i_cur <= nm1_reg && j_reg <= nm1_reg))
        else $error("state index out of range");

    // a write request never starts a decode
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_WRITE) |=> (state_reg == S_IDLE))
        else $error("write request left the block busy");

endmodule
